FILE: src/sactc_pkg.sv
// Shared constants for the set-associative FIFO-replacement tag check unit.
package sactc_pkg;

    localparam int ADDR_W       = 32;
    localparam int TAG_W        = 20;
    localparam int SET_W        = 6;
    localparam int NUM_SETS     = 64;
    localparam int SET_LSB      = 6;
    localparam int TAG_LSB      = 12;
    localparam int DEF_NUM_WAYS = 8;
    localparam int M_DATA_W     = 8;

endpackage

FILE: src/sactc_lookup.sv
// Parallel way compare and FIFO fill update for one cache set row.
module sactc_lookup #(
    parameter int NUM_WAYS = sactc_pkg::DEF_NUM_WAYS,
    parameter int HEAD_W   = 3,
    parameter int CNT_W    = 4
) (
    input  logic [sactc_pkg::TAG_W-1:0]                tag,
    input  logic [CNT_W-1:0]                           count,
    input  logic [HEAD_W-1:0]                          head,
    input  logic [NUM_WAYS-1:0][sactc_pkg::TAG_W-1:0]  tags,
    output logic                                       hit,
    output logic [NUM_WAYS-1:0][sactc_pkg::TAG_W-1:0]  new_tags,
    output logic [CNT_W-1:0]                           new_count,
    output logic [HEAD_W-1:0]                          new_head
);
    import sactc_pkg::*;

    logic [NUM_WAYS-1:0] way_hit;

    // ways below the count are valid: not full means oldest is way 0,
    // full means every way is valid
    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            way_hit[w]  = (CNT_W'(w) < count) && (tags[w] == tag);
        end
    end

    assign hit = |way_hit;

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            new_tags[w] = (!hit && (HEAD_W'(w) == head)) ? tag : tags[w];
        end
    end

    // head wraps; on a full set the oldest slot coincides with the head
    assign new_head  = (head == HEAD_W'(NUM_WAYS - 1)) ? '0 : head + 1'b1;
    assign new_count = (count == CNT_W'(NUM_WAYS)) ? count : count + 1'b1;

endmodule

FILE: src/set_assoc_cache_fifo_tag_check_unit.sv
// Top level: set-associative tag check with FIFO replacement per set.
//
//  channel | dir | ports                        | transaction
//  --------+-----+------------------------------+-------------------------------
//  s_      | in  | s_tvalid s_tready s_tdata    | one line address per access
//  m_      | out | m_tvalid m_tready m_tdata    | hit flag and set index
//
//  Cycles: one access per cycle while m_tready stays high; the access is
//  registered in the lookup stage along with its row read, and its result in
//  the output register. The single port-pair row memory does one read and one
//  write per cycle: each access reads its set row, compares all ways in
//  parallel and writes the row back on a miss.
//  Back-to-back accesses to the same set take the write-back row through a
//  bypass register instead of the stale memory read.
//  Reset: a 64-bit row-valid vector clears at once; a row not yet written
//  reads as an empty set. No clearing pass is needed.
//  Stalls: m_tready low holds the output register; the lookup stage holds
//  while the output is full and m_tready is low, and s_tready drops only then.
module set_assoc_cache_fifo_tag_check_unit #(
    parameter int NUM_WAYS = sactc_pkg::DEF_NUM_WAYS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: [31:0] address
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sactc_pkg::ADDR_W-1:0]    s_tdata,
    // m_tdata: [0] hit, [6:1] set_index, [7] zero
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sactc_pkg::M_DATA_W-1:0]  m_tdata
);
    import sactc_pkg::*;

    localparam int HEAD_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int CNT_W  = $clog2(NUM_WAYS + 1);

    // one row per set: tags of all ways plus the FIFO metadata
    typedef struct packed {
        logic [HEAD_W-1:0]                head;
        logic [CNT_W-1:0]                 count;
        logic [NUM_WAYS-1:0][TAG_W-1:0]   tags;
    } row_t;

    row_t row_mem [NUM_SETS];

    // input side
    logic               s_accept;
    logic [SET_W-1:0]   s_set;
    logic [TAG_W-1:0]   s_tag;

    // lookup stage
    logic               s1_valid_reg, s1_valid_next;
    logic [SET_W-1:0]   s1_set_reg;
    logic [TAG_W-1:0]   s1_tag_reg;
    row_t               rd_row_reg;
    logic               mvld_reg;       // row of this set written since reset
    logic               fwd_reg;        // take bypass row instead of memory
    row_t               fwd_row_reg;
    logic               s1_adv;

    logic [NUM_SETS-1:0] meta_vld_reg, meta_vld_next;

    // current row view
    logic [CNT_W-1:0]               cur_count;
    logic [HEAD_W-1:0]              cur_head;
    logic [NUM_WAYS-1:0][TAG_W-1:0] cur_tags;

    // lookup results
    logic                           lk_hit;
    row_t                           wr_row;
    logic                           wr_en;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic               m_hit_reg;
    logic [SET_W-1:0]   m_set_reg;

    assign s_set    = s_tdata[SET_LSB +: SET_W];
    assign s_tag    = s_tdata[TAG_LSB +: TAG_W];

    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_accept = s_tvalid && s_tready;

    // a hit leaves the row unchanged, so only misses write back
    assign wr_en    = s1_adv && !lk_hit;

    // bypass row wins; an unwritten row is an empty set
    always_comb begin
        cur_tags = fwd_reg ? fwd_row_reg.tags : rd_row_reg.tags;
        if (fwd_reg) begin
            cur_count = fwd_row_reg.count;
            cur_head  = fwd_row_reg.head;
        end else if (mvld_reg) begin
            cur_count = rd_row_reg.count;
            cur_head  = rd_row_reg.head;
        end else begin
            cur_count = '0;
            cur_head  = '0;
        end
    end

    sactc_lookup #(
        .NUM_WAYS (NUM_WAYS),
        .HEAD_W   (HEAD_W),
        .CNT_W    (CNT_W)
    ) u_lookup (
        .tag       (s1_tag_reg),
        .count     (cur_count),
        .head      (cur_head),
        .tags      (cur_tags),
        .hit       (lk_hit),
        .new_tags  (wr_row.tags),
        .new_count (wr_row.count),
        .new_head  (wr_row.head)
    );

    // row memory: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            row_mem[s1_set_reg] <= wr_row;
        end
        if (s_accept) begin
            rd_row_reg <= row_mem[s_set];
        end
    end

    // lookup stage payload, bypass row and output payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_set_reg  <= s_set;
            s1_tag_reg  <= s_tag;
            fwd_row_reg <= wr_row;
        end
        if (s1_adv) begin
            m_hit_reg <= lk_hit;
            m_set_reg <= s1_set_reg;
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (s1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end

        meta_vld_next = meta_vld_reg;
        if (wr_en) begin
            meta_vld_next[s1_set_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            meta_vld_reg <= '0;
            mvld_reg     <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            meta_vld_reg <= meta_vld_next;
            if (s_accept) begin
                // same-set write in this cycle is missed by the memory read
                mvld_reg <= meta_vld_reg[s_set];
                fwd_reg  <= wr_en && (s1_set_reg == s_set);
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_set_reg, m_hit_reg};

endmodule

FILE: test/cache_hit_checker.sv
// Checker for the tag check unit: predicts hit and set per access and compares results.
module cache_hit_checker #(
    parameter int WAYS = sactc_pkg::DEF_NUM_WAYS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: [31:0] address
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [sactc_pkg::ADDR_W-1:0]    s_tdata,
    // m_tdata: [0] hit, [6:1] set_index, [7] zero
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [sactc_pkg::M_DATA_W-1:0]  m_tdata,
    output int                              fail_count,
    output int                              lookups_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                      hit;
        logic [sactc_pkg::SET_W-1:0] set_index;
    } lookup_result_t;

    logic [sactc_pkg::TAG_W-1:0] line_tags [sactc_pkg::NUM_SETS][WAYS];
    int next_fill_way [sactc_pkg::NUM_SETS];
    int oldest_way    [sactc_pkg::NUM_SETS];
    int lines_held    [sactc_pkg::NUM_SETS];

    lookup_result_t pending_lookups [$];
    int errors = 0;

    // Tag search over the valid ways of the set, then FIFO fill on a miss.
    function automatic lookup_result_t lookup_and_fill(logic [sactc_pkg::ADDR_W-1:0] addr);
        lookup_result_t              res;
        logic [sactc_pkg::SET_W-1:0] set;
        logic [sactc_pkg::TAG_W-1:0] tag;
        int                          way;
        set = addr[sactc_pkg::TAG_LSB-1:sactc_pkg::SET_LSB];
        tag = addr[sactc_pkg::ADDR_W-1:sactc_pkg::TAG_LSB];
        res.hit = 1'b0;
        res.set_index = set;
        way = oldest_way[set];
        for (int k = 0; k < lines_held[set]; k++) begin
            if (line_tags[set][way] == tag) res.hit = 1'b1;
            way = (way + 1 == WAYS) ? 0 : way + 1;
        end
        if (!res.hit) begin
            if (lines_held[set] == WAYS) begin
                oldest_way[set] = (oldest_way[set] + 1 == WAYS) ? 0 : oldest_way[set] + 1;
                lines_held[set]--;
            end
            line_tags[set][next_fill_way[set]] = tag;
            next_fill_way[set] = (next_fill_way[set] + 1 == WAYS) ? 0 : next_fill_way[set] + 1;
            lines_held[set]++;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        lookup_result_t want;
        if (!aresetn) begin
            for (int s = 0; s < sactc_pkg::NUM_SETS; s++) begin
                next_fill_way[s] = 0;
                oldest_way[s]    = 0;
                lines_held[s]    = 0;
                for (int w = 0; w < WAYS; w++) line_tags[s][w] = '0;
            end
            pending_lookups.delete();
        end else begin
            // a result always belongs to an earlier access, so compare before pushing
            if (m_tvalid && m_tready) begin
                if (pending_lookups.size() == 0) begin
                    $error("result with no access waiting: m_tdata=0x%02h", m_tdata);
                    errors++;
                end else begin
                    want = pending_lookups.pop_front();
                    if (m_tdata[0] !== want.hit) begin
                        $error("hit: expected %0d, actual %0d", want.hit, m_tdata[0]);
                        errors++;
                    end
                    if (m_tdata[6:1] !== want.set_index) begin
                        $error("set_index: expected %0d, actual %0d",
                               want.set_index, m_tdata[6:1]);
                        errors++;
                    end
                    if (m_tdata[7] !== 1'b0) begin
                        $error("pad: expected 0, actual %0d", m_tdata[7]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) pending_lookups.push_back(lookup_and_fill(s_tdata));
        end
        fail_count        <= errors;
        lookups_in_flight <= pending_lookups.size();
    end

endmodule

FILE: test/set_assoc_cache_fifo_tag_check_unit_tb.sv
// Testbench top: drives line addresses into the tag check unit and gives the verdict.
module set_assoc_cache_fifo_tag_check_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WAYS        = sactc_pkg::DEF_NUM_WAYS;
    localparam int RANDOM_ACC  = 1535;   // random accesses after the directed part
    localparam int CALM_TAIL   = 250;    // last accesses run with no idling on either side
    localparam int SEGMENT     = 128;    // accesses per hot-set / tag-base segment
    localparam int DRAIN_WAIT  = 8;      // cycles after the last result
    localparam int STALL_LIMIT = 1000;   // cycles in a row with no transaction at all

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [sactc_pkg::ADDR_W-1:0]    s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [sactc_pkg::M_DATA_W-1:0]  m_tdata;

    int fail_count;
    int lookups_in_flight;
    bit idle_en = 1'b1;                  // cleared for the final stretch of the run
    int ready_stall = 0;

    // Recent addresses, replayed to force hits on lines that were filled earlier.
    logic [sactc_pkg::ADDR_W-1:0] recent_lines [16];
    int recent_wr = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    set_assoc_cache_fifo_tag_check_unit #(
        .NUM_WAYS (WAYS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    cache_hit_checker #(
        .WAYS (WAYS)
    ) u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .fail_count        (fail_count),
        .lookups_in_flight (lookups_in_flight)
    );

    // Result side backpressure: random bursts with tready low.
    always @(negedge aclk) begin
        if (ready_stall > 0) begin
            ready_stall--;
            m_tready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            ready_stall = $urandom_range(1, 11) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: any cycle with a transaction on either channel restarts the count.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // One access transaction. Called at a falling edge, returns at a falling edge.
    // A random gap lowers tvalid; otherwise tvalid stays high back to back.
    task automatic send_access(input logic [sactc_pkg::ADDR_W-1:0] addr);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        recent_lines[recent_wr] = addr;
        recent_wr = (recent_wr + 1) % 16;
    endtask

    // Hold the sender until every outstanding access has produced its result.
    task automatic drain_lookups();
        s_tvalid <= 1'b0;
        wait (lookups_in_flight == 0);
        @(negedge aclk);
    endtask

    // Builds a line address from set and tag; byte offset bits are random (ignored).
    function automatic logic [sactc_pkg::ADDR_W-1:0] line_addr(
        logic [sactc_pkg::TAG_W-1:0] tag, logic [sactc_pkg::SET_W-1:0] set);
        return {tag, set, 6'($urandom_range(0, 63))};
    endfunction

    initial begin
        logic [sactc_pkg::TAG_W-1:0] tag_base;
        logic [sactc_pkg::SET_W-1:0] hot_base;
        logic [sactc_pkg::ADDR_W-1:0] addr;
        int pick;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ---- directed part ----
        // empty set: miss at address zero, then the same line at the top byte offset hits
        send_access(32'h0000_0000);
        send_access(32'h0000_003F);
        // largest tag in set 0 sits beside tag 0
        send_access(32'hFFFF_F000);
        // all ones: set 63, largest tag, miss then hit
        send_access(32'hFFFF_FFFF);
        send_access(32'hFFFF_FFC0);
        // fill set 5 past capacity: the last fill evicts the oldest tag
        tag_base = 20'($urandom);
        for (int i = 1; i <= WAYS + 1; i++) send_access(line_addr(tag_base + 20'(i), 6'd5));
        // evicted tag misses again (and pushes out the next oldest), newest still hits
        send_access(line_addr(tag_base + 20'd1, 6'd5));
        send_access(line_addr(tag_base + 20'(WAYS + 1), 6'd5));
        drain_lookups();

        // ---- random part ----
        // Most accesses go to a few hot sets with a tag pool just larger than the
        // associativity, so sets fill, wrap and evict; the rest replay recent lines
        // or spray fully random addresses across all sets and tag bits.
        for (int n = 0; n < RANDOM_ACC; n++) begin
            if (n % SEGMENT == 0) begin
                tag_base = 20'($urandom);
                hot_base = 6'($urandom_range(0, 63));
            end
            if (n == RANDOM_ACC - CALM_TAIL) idle_en = 1'b0;
            // sender holds off until every result is back, a few times in the run
            if (n % 400 == 399) drain_lookups();
            pick = $urandom_range(0, 99);
            if (pick < 60)
                addr = line_addr(tag_base ^ 20'($urandom_range(0, WAYS + 3)),
                                 hot_base + 6'($urandom_range(0, 3)));
            else if (pick < 80)
                addr = {recent_lines[$urandom_range(0, 15)][31:6], 6'($urandom_range(0, 63))};
            else
                addr = $urandom;
            send_access(addr);
        end
        s_tvalid <= 1'b0;

        // wait for the last results, then a few cycles for anything unexpected
        wait (lookups_in_flight == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (fail_count == 0 && lookups_in_flight == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: files.f
src/sactc_pkg.sv
src/sactc_lookup.sv
src/set_assoc_cache_fifo_tag_check_unit.sv
test/cache_hit_checker.sv
test/set_assoc_cache_fifo_tag_check_unit_tb.sv
